### rtl/core/wdwr_pkg.sv
package wdwr_pkg;

  localparam int TABLE_ENTRIES_DEF = 64;
  localparam int ID_W     = 16;
  localparam int LEVEL_W  = 8;
  localparam int WEIGHT_W = 16;
  localparam int COUNT_W  = 7;
  localparam int RAND_W   = 31;
  localparam int STATUS_W = 2;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_LOAD  = 2'd1,
    OP_START = 2'd2,
    OP_DRAW  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_DONE  = 2'd3
  } status_t;

  // Command flowing along the cell row, one hop per cycle.
  typedef enum logic [2:0] {
    CM_NONE  = 3'd0,
    CM_SUM   = 3'd1,
    CM_SCAN  = 3'd2,
    CM_LOAD  = 3'd3,
    CM_CLRRM = 3'd4
  } cmd_t;

  typedef struct packed {
    cmd_t               cmd;
    logic [ID_W-1:0]    id;
    logic [LEVEL_W-1:0] level;
    logic [WEIGHT_W-1:0] weight;
    logic [RAND_W-1:0]  acc;     // running sum or remaining random
    logic               found;   // scan hit or load resolved
    logic [ID_W-1:0]    hit_id;
    logic               ovw_only; // load into a full table: overwrite only
    logic               shift;   // load: insertion point passed, shift carried entry
    logic               sh_valid;
    logic [ID_W-1:0]    sh_id;
    logic [LEVEL_W-1:0] sh_level;
    logic [WEIGHT_W-1:0] sh_weight;
    logic               sh_rm;
  } beat_t;

endpackage

### rtl/core/weighted_draw_without_replacement.sv
// Weighted draw without replacement. Each command (clear, load, start round, draw)
// is taken when start is high and busy is low, and gives exactly one result beat,
// marked by out_valid for one cycle; the receiver cannot stall, so take every beat.
// Entries live in a row of TABLE_ENTRIES cells kept in ascending id order; a
// command walks the row one cell a cycle. A clear gives its beat in the cycle after
// acceptance and never raises busy; a start holds busy for one cycle. A load walks
// the row once; a draw runs a sum pass, a 31-step serial modulo and a scan pass.
// A draw that finds an empty pool ends after the sum pass, and a draw in a finished
// round answers without a row walk. A new id into a full table leaves the table as
// it is and reports table full. cfg_we writes the eligible level; write it only
// while busy is low and no beat is pending.
module weighted_draw_without_replacement #(
  parameter int TABLE_ENTRIES = wdwr_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    in_operation,
  input  logic [wdwr_pkg::ID_W-1:0]     in_entry_id,
  input  logic [wdwr_pkg::LEVEL_W-1:0]  in_entry_level,
  input  logic [wdwr_pkg::WEIGHT_W-1:0] in_entry_weight,
  input  logic [wdwr_pkg::COUNT_W-1:0]  in_draw_count,
  input  logic [wdwr_pkg::RAND_W-1:0]   in_random_value,
  input  logic                          cfg_we,
  input  logic [7:0]                    cfg_data,
  output logic                          out_valid,
  output logic [wdwr_pkg::ID_W-1:0]     out_picked_id,
  output logic [1:0]                    out_status,
  output logic                          out_round_complete
);
  import wdwr_pkg::*;
  localparam int UW = $clog2(TABLE_ENTRIES + 1);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001, S_SUM = 6'b000010, S_MOD = 6'b000100,
    S_SCAN = 6'b001000, S_LOAD = 6'b010000, S_RESP = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic [7:0] elig_r;
  logic [UW-1:0] used_r, used_nxt;
  logic [COUNT_W-1:0] done_r, done_nxt, want_r, want_nxt;
  logic [RAND_W-1:0] rand_r, rand_nxt;
  beat_t head, tail;
  beat_t chain [TABLE_ENTRIES+1];
  logic clear_all;
  logic mod_go, mod_done;
  logic [RAND_W-1:0] mod_rem;
  logic ov_nxt, rc_nxt;
  logic [ID_W-1:0] pid_nxt;
  logic [1:0] st_nxt;
  logic ov_r, rc_r;
  logic [ID_W-1:0] pid_r;
  logic [1:0] st_r;
  logic accept;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;
  assign chain[0] = head;
  assign tail = chain[TABLE_ENTRIES];

  genvar g;
  for (g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    wdwr_cell u_cell (.clk, .rst_n, .elig_level(elig_r), .clear_all,
                      .beat_in(chain[g]), .beat_out(chain[g+1]));
  end

  wdwr_mod u_mod (.clk, .rst_n, .go(mod_go), .num(rand_r), .den(tail.acc),
                  .done(mod_done), .rem(mod_rem));

  always_comb begin
    state_nxt = state_r; used_nxt = used_r; done_nxt = done_r; want_nxt = want_r;
    rand_nxt = rand_r;
    head = '0; head.cmd = CM_NONE;
    clear_all = 1'b0; mod_go = 1'b0;
    ov_nxt = 1'b0; rc_nxt = 1'b0; pid_nxt = '0; st_nxt = ST_OK;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (op_t'(in_operation))
            OP_CLEAR: begin
              clear_all = 1'b1; used_nxt = '0; done_nxt = '0; want_nxt = '0;
              ov_nxt = 1'b1;
            end
            OP_START: begin
              head.cmd = CM_CLRRM; done_nxt = '0; want_nxt = in_draw_count;
              state_nxt = S_RESP;  // hold busy in S_RESP while clearing enters the row
              ov_nxt = 1'b1;
            end
            OP_LOAD: begin
              head.cmd = CM_LOAD; head.id = in_entry_id;
              head.level = in_entry_level; head.weight = in_entry_weight;
              // a full table only takes overwrites; hold every entry in place
              head.ovw_only = (used_r == UW'(TABLE_ENTRIES));
              state_nxt = S_LOAD;
            end
            OP_DRAW: begin
              if (done_r >= want_r) begin
                ov_nxt = 1'b1; st_nxt = ST_DONE;
              end else begin
                head.cmd = CM_SUM; rand_nxt = in_random_value; state_nxt = S_SUM;
              end
            end
            default: ;
          endcase
        end
      end
      S_SUM: begin
        if (tail.cmd == CM_SUM) begin
          if (tail.acc == '0) begin
            ov_nxt = 1'b1; st_nxt = ST_EMPTY; state_nxt = S_IDLE;
          end else begin
            mod_go = 1'b1; state_nxt = S_MOD;
          end
        end
      end
      S_MOD: begin
        if (mod_done) begin
          head.cmd = CM_SCAN; head.acc = mod_rem; state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (tail.cmd == CM_SCAN) begin
          ov_nxt = 1'b1; pid_nxt = tail.hit_id;
          done_nxt = done_r + COUNT_W'(1);
          rc_nxt = (done_nxt == want_r);
          state_nxt = S_IDLE;
        end
      end
      S_LOAD: begin
        if (tail.cmd == CM_LOAD) begin
          ov_nxt = 1'b1;
          // an unresolved load means a new id met a full table
          if (!tail.found) st_nxt = ST_FULL;
          else if (tail.acc != '0) used_nxt = used_r + UW'(1);
          state_nxt = S_IDLE;
        end
      end
      S_RESP: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; elig_r <= 8'd1; used_r <= '0; done_r <= '0; want_r <= '0;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt; used_r <= used_nxt; done_r <= done_nxt; want_r <= want_nxt;
      ov_r <= ov_nxt;
      if (cfg_we) elig_r <= cfg_data;
    end
    rand_r <= rand_nxt; pid_r <= pid_nxt; st_r <= st_nxt; rc_r <= rc_nxt;
  end

  assign out_valid = ov_r;
  assign out_picked_id = pid_r;
  assign out_status = st_r;
  assign out_round_complete = rc_r;

  a_one_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (state_r == S_IDLE || state_r == S_RESP))
    else $error("beat during a row walk");
  a_rc_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_round_complete |-> out_valid && out_status == ST_OK) else $error("rc");
  a_used: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= UW'(TABLE_ENTRIES)) else $error("used overflow");
endmodule

### rtl/core/wdwr_cell.sv
module wdwr_cell (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [7:0]            elig_level,
  input  logic                  clear_all,
  input  wdwr_pkg::beat_t       beat_in,
  output wdwr_pkg::beat_t       beat_out
);
  import wdwr_pkg::*;

  logic                valid_r, valid_nxt;
  logic                rm_r, rm_nxt;
  logic [ID_W-1:0]     id_r, id_nxt;
  logic [LEVEL_W-1:0]  lvl_r, lvl_nxt;
  logic [WEIGHT_W-1:0] wt_r, wt_nxt;
  beat_t               out_nxt, beat_r;
  logic                qual;

  assign qual = valid_r && !rm_r && (lvl_r == elig_level) && (wt_r != '0);

  always_comb begin
    out_nxt   = beat_in;
    valid_nxt = valid_r;
    rm_nxt    = rm_r;
    id_nxt    = id_r;
    lvl_nxt   = lvl_r;
    wt_nxt    = wt_r;
    unique case (beat_in.cmd)
      CM_SUM: begin
        if (qual) out_nxt.acc = beat_in.acc + RAND_W'(wt_r);
      end
      CM_SCAN: begin
        if (qual && !beat_in.found) begin
          if (beat_in.acc < RAND_W'(wt_r)) begin
            out_nxt.found  = 1'b1;
            out_nxt.hit_id = id_r;
            rm_nxt         = 1'b1;
          end else begin
            out_nxt.acc = beat_in.acc - RAND_W'(wt_r);
          end
        end
      end
      CM_CLRRM: rm_nxt = 1'b0;
      CM_LOAD: begin
        if (beat_in.shift) begin
          // carry the displaced entry one slot along
          valid_nxt = beat_in.sh_valid;
          id_nxt    = beat_in.sh_id;
          lvl_nxt   = beat_in.sh_level;
          wt_nxt    = beat_in.sh_weight;
          rm_nxt    = beat_in.sh_rm;
          out_nxt.sh_valid  = valid_r;
          out_nxt.sh_id     = id_r;
          out_nxt.sh_level  = lvl_r;
          out_nxt.sh_weight = wt_r;
          out_nxt.sh_rm     = rm_r;
          if (!beat_in.sh_valid) out_nxt.shift = 1'b0;
        end else if (!beat_in.found) begin
          if (!valid_r) begin
            valid_nxt = 1'b1;
            id_nxt = beat_in.id; lvl_nxt = beat_in.level; wt_nxt = beat_in.weight;
            rm_nxt = 1'b0;
            out_nxt.found = 1'b1;
            out_nxt.acc   = RAND_W'(1);   // inserted new entry
          end else if (id_r == beat_in.id) begin
            lvl_nxt = beat_in.level; wt_nxt = beat_in.weight;
            out_nxt.found = 1'b1;
          end else if (id_r > beat_in.id && !beat_in.ovw_only) begin
            id_nxt = beat_in.id; lvl_nxt = beat_in.level; wt_nxt = beat_in.weight;
            rm_nxt = 1'b0;
            out_nxt.found     = 1'b1;
            out_nxt.acc       = RAND_W'(1);
            out_nxt.shift     = 1'b1;
            out_nxt.sh_valid  = 1'b1;
            out_nxt.sh_id     = id_r;
            out_nxt.sh_level  = lvl_r;
            out_nxt.sh_weight = wt_r;
            out_nxt.sh_rm     = rm_r;
          end
        end
      end
      default: ;
    endcase
    if (clear_all) begin
      valid_nxt = 1'b0;
      rm_nxt    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= 1'b0;
      rm_r       <= 1'b0;
      beat_r.cmd <= CM_NONE;
    end else begin
      valid_r <= valid_nxt;
      rm_r    <= rm_nxt;
      beat_r  <= out_nxt;
    end
    id_r  <= id_nxt;
    lvl_r <= lvl_nxt;
    wt_r  <= wt_nxt;
  end

  assign beat_out = beat_r;
endmodule

### rtl/core/wdwr_mod.sv
module wdwr_mod (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        go,
  input  logic [wdwr_pkg::RAND_W-1:0] num,
  input  logic [wdwr_pkg::RAND_W-1:0] den,
  output logic                        done,
  output logic [wdwr_pkg::RAND_W-1:0] rem
);
  import wdwr_pkg::*;
  localparam int CW = $clog2(RAND_W + 1);

  logic [RAND_W:0]   rem_r, rem_nxt;
  logic [RAND_W-1:0] q_r, q_nxt;
  logic [RAND_W-1:0] den_r, den_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt, done_r, done_nxt;
  logic [RAND_W:0]   trial;

  always_comb begin
    rem_nxt = rem_r; q_nxt = q_r; cnt_nxt = cnt_r; den_nxt = den_r;
    busy_nxt = busy_r; done_nxt = 1'b0;
    trial = {rem_r[RAND_W-1:0], q_r[RAND_W-1]};
    if (go) begin
      rem_nxt = '0; q_nxt = num; den_nxt = den; cnt_nxt = CW'(RAND_W); busy_nxt = 1'b1;
    end else if (busy_r) begin
      // one restoring step a cycle
      q_nxt = {q_r[RAND_W-2:0], 1'b0};
      if (trial >= {1'b0, den_r}) rem_nxt = trial - {1'b0, den_r};
      else rem_nxt = trial;
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0; done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0; cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt; cnt_r <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    den_r <= den_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r[RAND_W-1:0];
endmodule
